// ----- rtl/bcrf_pkg.sv -----
// ----------------------------------------------------------------------------
// bcrf_pkg
// Shared types and constants of the border connected region fill core:
// request and response payloads, widths and default sizes.
// ----------------------------------------------------------------------------
package bcrf_pkg;

   localparam int RowW       = 64;
   localparam int ColsW      = 7;
   localparam int MaxRowsDef = 64;
   localparam int MaxColsDef = 64;

   localparam logic [ColsW-1:0] ColsReset = 7'd64;

   typedef struct packed {
      logic [RowW-1:0] row_cells;
      logic            last_row;
   } req_type;

   typedef struct packed {
      logic [RowW-1:0] filled_row;
      logic            last_out;
   } rsp_type;

endpackage

// ----- rtl/bcrf_ram.sv -----
// ----------------------------------------------------------------------------
// bcrf_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module bcrf_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/border_connected_region_fill_core.sv -----
// ----------------------------------------------------------------------------
// border_connected_region_fill_core
// Loads a binary grid one row per transfer (set bit = open cell), finds every
// open cell 4-connected to an open border cell and returns all rows, with
// enclosed open cells cleared.
// ----------------------------------------------------------------------------
// Rows load one per cycle while busy is low. After the last row (last_row set,
// or the MAX_ROWS-th row) busy stays high while a single row update unit works
// over the row store: a seed pass, then repeated sweeps until a sweep changes
// nothing, then an output pass. The sweep count depends on the grid and is at
// least one. Each sweep moves reach one column sideways and one row up, and
// down by one row per row visited. Results stream out one row per cycle on
// rsp_strobe and cannot be held off.
module border_connected_region_fill_core #(
   parameter int MAX_ROWS = bcrf_pkg::MaxRowsDef,
   parameter int MAX_COLS = bcrf_pkg::MaxColsDef
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  bcrf_pkg::req_type             req_data,
   output logic                          rsp_strobe,
   output bcrf_pkg::rsp_type             rsp_data,
   input  logic                          csr_wr_en,
   input  logic [bcrf_pkg::ColsW-1:0]    csr_wr_data
);

   localparam int AddrW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int CntW  = $clog2(MAX_ROWS + 1);
   localparam int RowW  = bcrf_pkg::RowW;
   localparam int ColsW = bcrf_pkg::ColsW;

   localparam logic [CntW:0]    MaxRowsC = (CntW + 1)'(MAX_ROWS);
   localparam logic [ColsW-1:0] MaxColsC = ColsW'(MAX_COLS);
   localparam logic [ColsW-1:0] FullColsC = ColsW'(RowW);

   typedef enum logic [9:0] {
      S_LOAD    = 10'b00_0000_0001,
      S_SEED_RD = 10'b00_0000_0010,
      S_SEED_WR = 10'b00_0000_0100,
      S_SW_A    = 10'b00_0000_1000,
      S_SW_B    = 10'b00_0001_0000,
      S_SW_G    = 10'b00_0010_0000,
      S_SW_C    = 10'b00_0100_0000,
      S_SW_END  = 10'b00_1000_0000,
      S_OUT_RD  = 10'b01_0000_0000,
      S_OUT_WR  = 10'b10_0000_0000
   } state_type;

   state_type              state_ff, state_in;
   logic [CntW-1:0]        row_cnt_ff, row_cnt_in;
   logic [CntW-1:0]        n_ff, n_in;
   logic [CntW-1:0]        r_ff, r_in;
   logic [ColsW-1:0]       cols_cfg_ff;
   logic [RowW-1:0]        up_ff, up_in;
   logic [RowW-1:0]        cur_ff, cur_in;
   logic [RowW-1:0]        g_ff, g_in;
   logic                   changed_ff, changed_in;
   logic                   strobe_ff, strobe_in;
   bcrf_pkg::rsp_type      rsp_ff, rsp_in;

   logic [ColsW-1:0]       cols_eff;
   logic [RowW-1:0]        col_mask;
   logic [RowW-1:0]        edge_mask;
   logic [CntW:0]          r_p1, r_p2, cnt_p1, n_ext;
   logic                   accept, grid_end;

   logic                   grid_we;
   logic [AddrW-1:0]       grid_waddr, grid_raddr;
   logic [RowW-1:0]        grid_wdata, grid_q;
   logic                   reach_we;
   logic [AddrW-1:0]       reach_waddr, reach_raddr;
   logic [RowW-1:0]        reach_wdata, reach_q;

   logic [RowW-1:0]        dn_val, nxt_row, seed_g;

   bcrf_ram #(.WIDTH(RowW), .DEPTH(MAX_ROWS), .AW(AddrW)) u_grid_ram (
      .clock   (clock),
      .wr_en   (grid_we),
      .wr_addr (grid_waddr),
      .wr_data (grid_wdata),
      .rd_addr (grid_raddr),
      .rd_data (grid_q)
   );

   bcrf_ram #(.WIDTH(RowW), .DEPTH(MAX_ROWS), .AW(AddrW)) u_reach_ram (
      .clock   (clock),
      .wr_en   (reach_we),
      .wr_addr (reach_waddr),
      .wr_data (reach_wdata),
      .rd_addr (reach_raddr),
      .rd_data (reach_q)
   );

   // column clamp and masks
   always_comb begin
      if (cols_cfg_ff == '0) begin
         cols_eff = ColsW'(1);
      end else if (cols_cfg_ff > MaxColsC) begin
         cols_eff = MaxColsC;
      end else begin
         cols_eff = cols_cfg_ff;
      end
      if (cols_eff >= FullColsC) begin
         col_mask = '1;
      end else begin
         col_mask = (RowW'(1) << cols_eff) - RowW'(1);
      end
      edge_mask = RowW'(1) | (RowW'(1) << (cols_eff - ColsW'(1)));
   end

   assign busy     = (state_ff != S_LOAD);
   assign accept   = start && !busy;
   assign r_p1     = {1'b0, r_ff} + (CntW + 1)'(1);
   assign r_p2     = {1'b0, r_ff} + (CntW + 1)'(2);
   assign cnt_p1   = {1'b0, row_cnt_ff} + (CntW + 1)'(1);
   assign n_ext    = {1'b0, n_ff};
   assign grid_end = req_data.last_row || (cnt_p1 == MaxRowsC);

   // row update unit
   assign seed_g  = grid_q & col_mask;
   assign dn_val  = (r_p1 < n_ext) ? reach_q : '0;
   assign nxt_row = (cur_ff | (cur_ff << 1) | (cur_ff >> 1) | up_ff | dn_val)
                    & g_ff & col_mask;

   assign grid_we    = accept;
   assign grid_waddr = row_cnt_ff[AddrW-1:0];
   assign grid_wdata = req_data.row_cells & col_mask;

   always_comb begin
      state_in    = state_ff;
      row_cnt_in  = row_cnt_ff;
      n_in        = n_ff;
      r_in        = r_ff;
      up_in       = up_ff;
      cur_in      = cur_ff;
      g_in        = g_ff;
      changed_in  = changed_ff;
      strobe_in   = 1'b0;
      rsp_in      = rsp_ff;
      grid_raddr  = r_ff[AddrW-1:0];
      reach_raddr = r_ff[AddrW-1:0];
      reach_we    = 1'b0;
      reach_waddr = r_ff[AddrW-1:0];
      reach_wdata = nxt_row;

      unique case (state_ff)
         S_LOAD: begin
            if (accept) begin
               if (grid_end) begin
                  n_in       = cnt_p1[CntW-1:0];
                  row_cnt_in = '0;
                  r_in       = '0;
                  state_in   = S_SEED_RD;
               end else begin
                  row_cnt_in = cnt_p1[CntW-1:0];
               end
            end
         end
         S_SEED_RD: begin
            state_in = S_SEED_WR;
         end
         S_SEED_WR: begin
            grid_raddr = r_p1[AddrW-1:0];
            reach_we   = 1'b1;
            if ((r_ff == '0) || (r_p1 == n_ext)) begin
               reach_wdata = seed_g;
            end else begin
               reach_wdata = seed_g & edge_mask;
            end
            if (r_p1 == n_ext) begin
               r_in     = '0;
               state_in = S_SW_A;
            end else begin
               r_in = r_p1[CntW-1:0];
            end
         end
         S_SW_A: begin
            up_in      = '0;
            changed_in = 1'b0;
            state_in   = S_SW_B;
         end
         S_SW_B: begin
            cur_in      = reach_q;
            reach_raddr = r_p1[AddrW-1:0];
            state_in    = S_SW_G;
         end
         S_SW_G: begin
            g_in        = grid_q;
            reach_raddr = r_p1[AddrW-1:0];
            state_in    = S_SW_C;
         end
         S_SW_C: begin
            reach_we    = 1'b1;
            grid_raddr  = r_p1[AddrW-1:0];
            reach_raddr = r_p2[AddrW-1:0];
            changed_in  = changed_ff || (nxt_row != cur_ff);
            up_in       = nxt_row;
            cur_in      = dn_val;
            if (r_p1 == n_ext) begin
               state_in = S_SW_END;
            end else begin
               r_in     = r_p1[CntW-1:0];
               state_in = S_SW_G;
            end
         end
         S_SW_END: begin
            r_in = '0;
            if (changed_ff) begin
               state_in = S_SW_A;
            end else begin
               state_in = S_OUT_RD;
            end
         end
         S_OUT_RD: begin
            state_in = S_OUT_WR;
         end
         S_OUT_WR: begin
            reach_raddr       = r_p1[AddrW-1:0];
            strobe_in         = 1'b1;
            rsp_in.filled_row = reach_q;
            rsp_in.last_out   = (r_p1 == n_ext);
            if (r_p1 == n_ext) begin
               state_in = S_LOAD;
            end else begin
               r_in = r_p1[CntW-1:0];
            end
         end
         default: begin
            state_in = S_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_LOAD;
         row_cnt_ff  <= '0;
         cols_cfg_ff <= bcrf_pkg::ColsReset;
         strobe_ff   <= 1'b0;
      end else begin
         state_ff   <= state_in;
         row_cnt_ff <= row_cnt_in;
         strobe_ff  <= strobe_in;
         if (csr_wr_en) begin
            cols_cfg_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      n_ff       <= n_in;
      r_ff       <= r_in;
      up_ff      <= up_in;
      cur_ff     <= cur_in;
      g_ff       <= g_in;
      changed_ff <= changed_in;
      rsp_ff     <= rsp_in;
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_data   = rsp_ff;

endmodule

// ----- rtl/bcrf_checker.sv -----
// ----------------------------------------------------------------------------
// bcrf_checker
// Port level checks of the border connected region fill core, bound to the
// top level.
// ----------------------------------------------------------------------------
module bcrf_checker (
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input bcrf_pkg::req_type req_data,
   input logic              rsp_strobe,
   input bcrf_pkg::rsp_type rsp_data
);

   // a grid end request starts the fill
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_data.last_row) |=> busy)
      else $error("no fill after last row transfer");

   // result rows stream without gaps until the last one
   assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_data.last_out) |=> rsp_strobe)
      else $error("gap in result row stream");

   // the last result row frees the input side
   assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.last_out) |-> !busy)
      else $error("still busy on last result row");

   // results only come out of a busy period
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(busy))
      else $error("result transfer without work");

endmodule

bind border_connected_region_fill_core bcrf_checker u_bcrf_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .req_data   (req_data),
   .rsp_strobe (rsp_strobe),
   .rsp_data   (rsp_data)
);

// ----- verif/border_connected_region_fill_core_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// border_connected_region_fill_core_tb
// Self-checking bench for the border region fill core. Grids of rows are
// queued by a stimulus process and fed by a bursty driver. A built-in
// flood-fill predictor computes the expected rows once a grid's last row is
// accepted, and a monitor compares every returned row against them, field by field.
// ----------------------------------------------------------------------------
module border_connected_region_fill_core_tb;

   localparam int MaxRows = bcrf_pkg::MaxRowsDef;
   localparam int MaxCols = bcrf_pkg::MaxColsDef;
   localparam int RowW    = bcrf_pkg::RowW;
   localparam int ColsW   = bcrf_pkg::ColsW;

   logic              clock       = 1'b0;
   logic              reset       = 1'b1;
   logic              start       = 1'b0;
   logic              busy;
   bcrf_pkg::req_type req_data    = '0;
   logic              rsp_strobe;
   bcrf_pkg::rsp_type rsp_data;
   logic              csr_wr_en   = 1'b0;
   logic [ColsW-1:0]  csr_wr_data = '0;

   bcrf_pkg::req_type pending_rows[$];
   bcrf_pkg::rsp_type filled_rows_due[$];
   logic [RowW-1:0]   loaded_rows[0:MaxRows-1];
   int                rows_held    = 0;
   logic [ColsW-1:0]  cols_setting = bcrf_pkg::ColsReset;

   bit               gaps_on      = 1'b1;
   int               burst_left   = 0;
   int               gap_left     = 0;
   int               error_count  = 0;
   int               rows_queued  = 0;
   int               open_rows    = 0;
   longint           cycle_budget = 0;
   longint           cycle_count  = 0;

   border_connected_region_fill_core DUT (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_data    (req_data),
      .rsp_strobe  (rsp_strobe),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int cols_in_use();
      int c;
      c = int'(cols_setting);
      if (c < 1) c = 1;
      if (c > MaxCols) c = MaxCols;
      return c;
   endfunction

   function automatic logic [RowW-1:0] column_mask(input int c);
      if (c >= RowW) return '1;
      return (64'd1 << c) - 64'd1;
   endfunction

   task automatic flood_from_border(input int n, input int c);
      logic [RowW-1:0]   reach[0:MaxRows-1];
      logic [RowW-1:0]   m;
      logic [RowW-1:0]   border_cols;
      logic [RowW-1:0]   grown;
      bcrf_pkg::rsp_type due;
      bit                moved;
      m = column_mask(c);
      border_cols = 64'd1 | (64'd1 << (c - 1));
      for (int r = 0; r < n; r++) begin
         if (r == 0 || r == n - 1) reach[r] = loaded_rows[r] & m;
         else reach[r] = loaded_rows[r] & m & border_cols;
      end
      do begin
         moved = 1'b0;
         for (int r = 0; r < n; r++) begin
            grown = reach[r] | (reach[r] << 1) | (reach[r] >> 1);
            if (r > 0) grown |= reach[r-1];
            if (r < n - 1) grown |= reach[r+1];
            grown &= loaded_rows[r] & m;
            if (grown != reach[r]) begin
               reach[r] = grown;
               moved = 1'b1;
            end
         end
      end while (moved);
      for (int r = 0; r < n; r++) begin
         due.filled_row = reach[r];
         due.last_out   = (r == n - 1);
         filled_rows_due.push_back(due);
      end
   endtask

   task automatic load_row(input bcrf_pkg::req_type item);
      int c;
      c = cols_in_use();
      if (rows_held >= MaxRows) rows_held = 0;
      loaded_rows[rows_held] = item.row_cells & column_mask(c);
      rows_held++;
      if (item.last_row || rows_held == MaxRows) begin
         flood_from_border(rows_held, c);
         rows_held = 0;
      end
   endtask

   task automatic report_mismatch(input string what);
      error_count++;
      $display("mismatch at %0t: %s", $time, what);
   endtask

   // driver: bursts of transfers with random gaps, holds while busy
   always @(posedge clock) begin
      if (reset) begin
         start      <= 1'b0;
         burst_left <= 0;
         gap_left   <= 0;
      end else begin
         if (start && !busy) begin
            load_row(req_data);
            void'(pending_rows.pop_front());
         end
         if (!start || !busy) begin
            if (gap_left != 0) begin
               start    <= 1'b0;
               gap_left <= gap_left - 1;
            end else if (pending_rows.size() != 0) begin
               start    <= 1'b1;
               req_data <= pending_rows[0];
               if (burst_left > 1) begin
                  burst_left <= burst_left - 1;
               end else begin
                  burst_left <= $urandom_range(1, 24);
                  gap_left   <= (gaps_on && $urandom_range(0, 3) != 0) ?
                                $urandom_range(1, 8) : 0;
               end
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      bcrf_pkg::rsp_type due;
      if (!reset && rsp_strobe) begin
         if (filled_rows_due.size() == 0) begin
            report_mismatch($sformatf("unexpected row %h", rsp_data.filled_row));
         end else begin
            due = filled_rows_due.pop_front();
            if (rsp_data.filled_row !== due.filled_row)
               report_mismatch($sformatf("filled_row got %h want %h",
                                         rsp_data.filled_row, due.filled_row));
            if (rsp_data.last_out !== due.last_out)
               report_mismatch($sformatf("last_out got %b want %b",
                                         rsp_data.last_out, due.last_out));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > 4 * cycle_budget + 20000) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   task automatic push_row(input logic [RowW-1:0] cells, input bit last);
      bcrf_pkg::req_type item;
      item.row_cells = cells;
      item.last_row  = last;
      pending_rows.push_back(item);
      rows_queued++;
      open_rows++;
      cycle_budget += 12;
      if (last || open_rows == MaxRows) begin
         cycle_budget += longint'(open_rows * MaxCols + 2) * (2 * open_rows + 3)
                         + 2 * open_rows + 10;
         open_rows = 0;
      end
   endtask

   function automatic logic [RowW-1:0] random_cells(input int style);
      logic [RowW-1:0] a, b, c;
      a = {$urandom, $urandom};
      b = {$urandom, $urandom};
      c = {$urandom, $urandom};
      case (style)
         0:       return a;
         1:       return a | b;
         2:       return a | b | c;
         3:       return a & b;
         default: return ~(a & b & c);
      endcase
   endfunction

   task automatic push_grid(input int n, input bit close_grid);
      int style;
      style = $urandom_range(0, 4);
      for (int r = 0; r < n; r++) push_row(random_cells(style), close_grid && r == n - 1);
   endtask

   task automatic wait_for_idle();
      while (pending_rows.size() != 0 || start || busy || filled_rows_due.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_cols(input logic [ColsW-1:0] value);
      wait_for_idle();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      cols_setting = value;
      csr_wr_en <= 1'b0;
      cycle_budget += 20;
   endtask

   initial begin
      int phase_no;
      int phase_rows;
      int n;
      logic [ColsW-1:0] v;

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // single row grids at reset width
      push_row('1, 1'b1);
      push_row('0, 1'b1);
      // enclosed bands next to border-reaching cells
      push_row(64'h0, 1'b0);
      push_row(64'h7FFF_FFFF_FFFF_FFFE, 1'b0);
      push_row(64'h5555_5555_5555_5555, 1'b0);
      push_row(64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
      push_row(64'h0, 1'b1);
      write_cols(7'd64);
      push_row(64'h0, 1'b0);
      push_row(64'h0000_0000_0000_0FF0, 1'b0);
      push_row(64'h0, 1'b1);
      // width changed in the middle of a grid
      write_cols(7'd8);
      push_row(64'hFFFF_FFFF_FFFF_FF00, 1'b0);
      push_row(64'h0000_0000_0000_0066, 1'b0);
      write_cols(7'd3);
      push_row(64'h0000_0000_0000_00FF, 1'b1);
      // single column, zero width, oversized width
      write_cols(7'd1);
      push_row(64'h1, 1'b0);
      push_row(64'h0, 1'b0);
      push_row(64'h1, 1'b0);
      push_row('1, 1'b1);
      write_cols(7'd0);
      push_row('1, 1'b0);
      push_row(64'h0, 1'b1);
      write_cols(7'd127);
      push_row(64'h8000_0000_0000_0000, 1'b0);
      push_row('1, 1'b0);
      push_row(64'h1, 1'b1);

      phase_no = 0;
      while (rows_queued < 370) begin
         case (phase_no % 8)
            0:       v = 7'd64;
            1:       v = 7'd127;
            2:       v = 7'd1;
            3:       v = 7'd0;
            5:       v = 7'($urandom_range(65, 126));
            6:       v = 7'd2;
            default: v = 7'($urandom_range(3, 63));
         endcase
         write_cols(v);
         gaps_on = ($urandom_range(0, 3) != 0);
         if (phase_no == 1) push_grid(MaxRows, 1'b0);
         if (phase_no == 4) push_grid(MaxRows, 1'b1);
         phase_rows = 0;
         while (phase_rows < 32 && rows_queued < 370) begin
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8);
            push_grid(n, 1'b1);
            phase_rows += n;
            if ($urandom_range(0, 5) == 0) wait_for_idle();
         end
         // leave a grid open across the next width write
         if (phase_no % 3 == 2) push_grid($urandom_range(1, 4), 1'b0);
         phase_no++;
      end
      if (open_rows != 0) push_row(random_cells(0), 1'b1);

      wait_for_idle();
      repeat (20) @(posedge clock);
      if (error_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/bcrf_pkg.sv
rtl/bcrf_ram.sv
rtl/border_connected_region_fill_core.sv
rtl/bcrf_checker.sv
verif/border_connected_region_fill_core_tb.sv
